### src/smm_pkg.sv
// Shared constants and control structs for the square matrix multiplier.
`default_nettype none
package smm_pkg;

  localparam int unsigned Dim     = 4;
  localparam int unsigned Cells   = Dim * Dim;
  localparam int unsigned IdxW    = $clog2(Dim);
  localparam int unsigned AddrW   = $clog2(Cells);
  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned TermW   = ProdW - FracW;
  localparam int unsigned AccW    = TermW + IdxW + 1;
  localparam int unsigned OutIdxW = 2;

  // Read request from the sequencer to the operand store.
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
  } smm_rd_t;

  // Write request from the sequencer to the operand store.
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] addr;
  } smm_wr_t;

  // Status of the multiply-accumulate pipeline.
  typedef struct packed {
    logic rd_vld;
    logic busy;
  } smm_mac_sts_t;

endpackage
`default_nettype wire

### src/smm_store.sv
// Operand store: one memory for A, one for B, registered read ports.
`default_nettype none
module smm_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smm_pkg::smm_wr_t                    wr_i,
  input  logic signed [smm_pkg::DataW-1:0]    a_wdata_i,
  input  logic signed [smm_pkg::DataW-1:0]    b_wdata_i,
  input  smm_pkg::smm_rd_t                    rd_i,
  output logic signed [smm_pkg::DataW-1:0]    a_rdata_o,
  output logic signed [smm_pkg::DataW-1:0]    b_rdata_o,
  output logic                                rd_vld_o
);
  import smm_pkg::*;

  logic [DataW-1:0] mem_a_q [Cells];
  logic [DataW-1:0] mem_b_q [Cells];
  logic [DataW-1:0] a_rd_q;
  logic [DataW-1:0] b_rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem_a_q[wr_i.addr] <= a_wdata_i;
      mem_b_q[wr_i.addr] <= b_wdata_i;
    end
    if (rd_i.rd_en) begin
      a_rd_q <= mem_a_q[rd_i.addr_a];
      b_rd_q <= mem_b_q[rd_i.addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_i.rd_en;
    end
  end

  assign a_rdata_o = a_rd_q;
  assign b_rdata_o = b_rd_q;
  assign rd_vld_o  = rd_vld_q;

endmodule
`default_nettype wire

### src/smm_mac.sv
// Shared multiply-accumulate unit with Q16.16 rescale and output saturation.
`default_nettype none
module smm_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_clr_i,
  input  logic                             rd_vld_i,
  input  logic signed [smm_pkg::DataW-1:0] a_i,
  input  logic signed [smm_pkg::DataW-1:0] b_i,
  output smm_pkg::smm_mac_sts_t            sts_o,
  output logic signed [smm_pkg::DataW-1:0] sat_o
);
  import smm_pkg::*;

  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin =
    {{(AccW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [ProdW-1:0] prod_sh;
  logic        [TermW-1:0] term;
  logic signed [AccW-1:0]  acc_d, acc_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_i) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= rd_vld_i;
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  assign prod_sh = prod_q >>> FracW;
  assign term    = prod_sh[TermW-1:0];

  always_comb begin
    acc_d = acc_q;
    if (acc_clr_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-TermW){term[TermW-1]}}, term};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    if (acc_q > SatMax) begin
      sat_o = SatMax[DataW-1:0];
    end else if (acc_q < SatMin) begin
      sat_o = SatMin[DataW-1:0];
    end else begin
      sat_o = acc_q[DataW-1:0];
    end
  end

  assign sts_o.rd_vld = rd_vld_i;
  assign sts_o.busy   = rd_vld_i | prod_vld_q;

endmodule
`default_nettype wire

### src/smm_ctrl.sv
// Sequencer: load counter, row/column/term counters and output handshake.
`default_nettype none
module smm_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output smm_pkg::smm_wr_t                  wr_o,
  output smm_pkg::smm_rd_t                  rd_o,
  output logic                              acc_clr_o,
  input  smm_pkg::smm_mac_sts_t             sts_i,
  output logic [smm_pkg::OutIdxW-1:0]       row_o,
  output logic [smm_pkg::OutIdxW-1:0]       col_o,
  output logic                              last_o
);
  import smm_pkg::*;

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StMac   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  localparam logic [AddrW-1:0] CntLast = AddrW'(Cells - 1);
  localparam logic [IdxW-1:0]  IdxLast = IdxW'(Dim - 1);

  logic [1:0]       state_d, state_q;
  logic [AddrW-1:0] cnt_d, cnt_q;
  logic [IdxW-1:0]  r_d, r_q, c_d, c_q, k_d, k_q;
  logic             in_acc, out_acc, elem_last;

  assign in_acc    = in_valid_i & in_ready_o;
  assign out_acc   = out_valid_o & out_ready_i;
  assign elem_last = (r_q == IdxLast) && (c_q == IdxLast);

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StOut);

  assign wr_o.wr_en = in_acc;
  assign wr_o.addr  = cnt_q;

  assign rd_o.rd_en  = (state_q == StMac);
  assign rd_o.addr_a = AddrW'(int'(r_q) * Dim + int'(k_q));
  assign rd_o.addr_b = AddrW'(int'(k_q) * Dim + int'(c_q));

  assign row_o  = OutIdxW'(r_q);
  assign col_o  = OutIdxW'(c_q);
  assign last_o = elem_last;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    acc_clr_o = 1'b0;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (cnt_q == CntLast) begin
            cnt_d     = '0;
            r_d       = '0;
            c_d       = '0;
            k_d       = '0;
            acc_clr_o = 1'b1;
            state_d   = StMac;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StMac: begin
        if (k_q == IdxLast) begin
          k_d     = '0;
          state_d = StDrain;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StDrain: begin
        // Hold until the last term has been added.
        if (!sts_i.busy) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (elem_last) begin
            state_d = StLoad;
          end else begin
            acc_clr_o = 1'b1;
            state_d   = StMac;
            if (c_q == IdxLast) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes open at once");

  a_out_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !sts_i.busy)
    else $error("result shown while terms still in flight");

  a_read_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.rd_en |=> sts_i.rd_vld)
    else $error("read issued without returning data");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast)
    else $error("load count past matrix size");

endmodule
`default_nettype wire

### src/square_matrix_multiply.sv
// Top level of the square matrix multiplier (signed Q16.16, saturated).
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+--------------------------
//  in      | in_valid_i, in_ready_o, a_value_i, b_value_i | one A/B pair, row-major
//  out     | out_valid_o, out_ready_i, product_value_o,   | one product element,
//          | row_index_o, col_index_o, is_last_o          | row-major
//
// Loading takes Dim*Dim items. The last item starts the product; each element
// then takes Dim reads into the one shared multiplier, a pipeline drain and an
// output handshake that out_ready_i can hold.
// Reset clears the sequencer and the pipeline valid flags; the operand memories
// need no clearing.
// Input ready is low from the last load until the final element is taken.
`default_nettype none
module square_matrix_multiply (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [smm_pkg::DataW-1:0]     a_value_i,
  input  logic signed [smm_pkg::DataW-1:0]     b_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [smm_pkg::DataW-1:0]     product_value_o,
  output logic        [smm_pkg::OutIdxW-1:0]   row_index_o,
  output logic        [smm_pkg::OutIdxW-1:0]   col_index_o,
  output logic                                 is_last_o
);
  import smm_pkg::*;

  smm_wr_t                 wr;
  smm_rd_t                 rd;
  smm_mac_sts_t            sts;
  logic                    acc_clr;
  logic                    rd_vld;
  logic signed [DataW-1:0] a_rdata;
  logic signed [DataW-1:0] b_rdata;

  smm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .wr_o        (wr),
    .rd_o        (rd),
    .acc_clr_o   (acc_clr),
    .sts_i       (sts),
    .row_o       (row_index_o),
    .col_o       (col_index_o),
    .last_o      (is_last_o)
  );

  smm_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .a_wdata_i (a_value_i),
    .b_wdata_i (b_value_i),
    .rd_i      (rd),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata),
    .rd_vld_o  (rd_vld)
  );

  smm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_clr_i (acc_clr),
    .rd_vld_i  (rd_vld),
    .a_i       (a_rdata),
    .b_i       (b_rdata),
    .sts_o     (sts),
    .sat_o     (product_value_o)
  );

endmodule
`default_nettype wire
